FILE: hw/rtl/mmbox_pkg.sv
// Package for the slot-based message mailbox.
// Holds request and status codes and the sequencer state codes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mmbox_pkg;
  localparam logic REQ_SEND = 1'b0;
  localparam logic REQ_RECV = 1'b1;
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_FAIL  = 1'b1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FREE  = 3'd1;
  localparam logic [2:0] S_CLEAR = 3'd2;
  localparam logic [2:0] S_STORE = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_READ  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;
  localparam logic [2:0] S_RESP  = 3'd7;
endpackage
`default_nettype wire

FILE: hw/rtl/message_mailbox_slots.sv
// Top level of the slot-based message mailbox: sequencer, slot tables, payload memory.
// Depends on mmbox_pkg.
//
// Usage: requests enter on the s_axis group, results leave on m_axis.
// A send is a run of word beats (req_type 0). The word_index 0 beat checks the
// header and searches the slots one per cycle for the lowest free one, then
// clears that slot's payload words one per cycle. Every word is then written to
// the payload memory; the last_word beat commits and gives one status beat.
// A receive (req_type 1) compares one slot per cycle with a single shared
// compare unit to find the oldest busy slot for dest_id, then reads and sends
// the payload words in turn, each waiting until the previous beat is taken,
// with tlast on the final one, and frees the slot. No match gives one failure beat.
// One request is in work at a time, and s_axis_tready is low meanwhile.
// Results sit in an output register; a stall on m_axis holds the sequencer
// until the beat is taken. Reset clears busy flags and the open send and sets
// the order counter to 1; slot contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module message_mailbox_slots #(
  parameter int SLOT_COUNT = 16,
  parameter int MSG_BYTES  = 32,
  parameter int ID_BITS    = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: sender_id[15:0], dest_id[31:16], byte_count[37:32], word_index[39:38],
  // payload_word[103:40]
  input  wire logic [103:0] s_axis_tdata,
  // tuser: req_type
  input  wire logic         s_axis_tuser,
  input  wire logic         s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata: status[0], from_id[16:1], to_id[32:17], msg_length[38:33],
  // out_word[102:39], zero fill to 104 bits
  output logic [103:0]      m_axis_tdata,
  output logic              m_axis_tlast
);
  localparam int WORDS = (MSG_BYTES + 7) / 8;
  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int WW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam int WCW = $clog2(WORDS + 1);

  logic [2:0] state;
  logic [SLOT_COUNT-1:0] slot_busy;
  logic [15:0] slot_sender [SLOT_COUNT];
  logic [15:0] slot_dest [SLOT_COUNT];
  logic [5:0] slot_length [SLOT_COUNT];
  logic [63:0] slot_order [SLOT_COUNT];
  logic [63:0] slot_payload [SLOT_COUNT*WORDS];

  logic [63:0] next_order;
  logic [SW-1:0] fill_slot;
  logic fill_ok;

  // Latched request.
  logic [15:0] r_dest;
  logic [5:0] r_cnt;
  logic [1:0] r_widx;
  logic [63:0] r_data;
  logic r_last;

  logic [CW-1:0] cnt;
  logic [WCW-1:0] wcnt;
  logic found;
  logic [SW-1:0] best;
  logic [63:0] best_order;
  logic [63:0] rd_word;
  logic [15:0] id_mask;

  logic [15:0] in_snd, in_dst;
  logic [SW-1:0] cur;
  logic [WW-1:0] wsel;
  logic [SW+WW-1:0] addr;

  assign id_mask = (ID_BITS >= 16) ? 16'hFFFF : 16'((17'd1 << ID_BITS) - 17'd1);
  assign in_snd = s_axis_tdata[15:0] & id_mask;
  assign in_dst = s_axis_tdata[31:16] & id_mask;
  assign cur = cnt[SW-1:0];
  assign wsel = wcnt[WW-1:0];
  assign s_axis_tready = (state == mmbox_pkg::S_IDLE) && !m_axis_tvalid;

  function automatic logic [63:0] keep_bytes(input logic [63:0] w, input logic [5:0] len,
                                             input logic [WW-1:0] idx);
    logic [8:0] start;
    logic [8:0] kept;
    logic [63:0] mask;
    begin
      start = 9'(idx) << 3;
      kept = 9'(len) - start;
      mask = '0;
      for (int b = 0; b < 8; b++) mask[b*8 +: 8] = {8{9'(b) < kept}};
      keep_bytes = ({3'd0, len} <= start) ? 64'd0 : (w & mask);
    end
  endfunction

  // Address into the payload memory, for the writes and for the read in S_READ.
  always_comb begin
    case (state)
      mmbox_pkg::S_CLEAR: addr = (SW+WW)'(fill_slot) * (SW+WW)'(WORDS) + (SW+WW)'(wsel);
      mmbox_pkg::S_READ:  addr = (SW+WW)'(best) * (SW+WW)'(WORDS) + (SW+WW)'(wsel);
      default:            addr = (SW+WW)'(fill_slot) * (SW+WW)'(WORDS) + (SW+WW)'(r_widx[WW-1:0]);
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == mmbox_pkg::S_CLEAR) slot_payload[addr] <= '0;
    else if (state == mmbox_pkg::S_STORE && fill_ok && 32'(r_widx) < WORDS)
      slot_payload[addr] <= keep_bytes(r_data, slot_length[fill_slot], r_widx[WW-1:0]);
    if (state == mmbox_pkg::S_READ) rd_word <= slot_payload[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmbox_pkg::S_IDLE;
      slot_busy <= '0;
      next_order <= 64'd1;
      fill_slot <= '0;
      fill_ok <= 1'b0;
      m_axis_tvalid <= 1'b0;
      cnt <= '0;
      wcnt <= '0;
      found <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        mmbox_pkg::S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            r_dest <= in_dst;
            r_cnt <= s_axis_tdata[37:32];
            r_widx <= s_axis_tdata[39:38];
            r_data <= s_axis_tdata[103:40];
            r_last <= s_axis_tlast;
            cnt <= '0;
            wcnt <= '0;
            found <= 1'b0;
            if (s_axis_tuser == mmbox_pkg::REQ_RECV) begin
              state <= (in_dst != 16'd0) ? mmbox_pkg::S_SCAN : mmbox_pkg::S_RESP;
            end else if (s_axis_tdata[39:38] == 2'd0) begin
              fill_ok <= 1'b0;
              if (in_snd != 16'd0 && in_dst != 16'd0 && s_axis_tdata[37:32] != 6'd0
                  && 32'(s_axis_tdata[37:32]) <= MSG_BYTES) begin
                state <= mmbox_pkg::S_FREE;
                // sender held in best_order low bits while searching
                best_order <= {48'd0, in_snd};
              end else state <= mmbox_pkg::S_STORE;
            end else state <= mmbox_pkg::S_STORE;
          end
        end
        mmbox_pkg::S_FREE: begin
          if (32'(cnt) >= SLOT_COUNT) state <= mmbox_pkg::S_STORE;
          else if (!slot_busy[cur]) begin
            fill_slot <= cur;
            fill_ok <= 1'b1;
            slot_sender[cur] <= best_order[15:0];
            slot_dest[cur] <= r_dest;
            slot_length[cur] <= r_cnt;
            state <= mmbox_pkg::S_CLEAR;
          end else cnt <= cnt + 1'b1;
        end
        mmbox_pkg::S_CLEAR: begin
          if (32'(wcnt) == WORDS - 1) state <= mmbox_pkg::S_STORE;
          else wcnt <= wcnt + 1'b1;
        end
        mmbox_pkg::S_STORE: begin
          if (r_last) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata <= {65'd0, 38'd0, (fill_ok ? mmbox_pkg::ST_OK : mmbox_pkg::ST_FAIL)};
            m_axis_tlast <= 1'b1;
            if (fill_ok) begin
              slot_busy[fill_slot] <= 1'b1;
              slot_order[fill_slot] <= next_order;
              next_order <= next_order + 64'd1;
            end
            fill_ok <= 1'b0;
          end
          state <= mmbox_pkg::S_IDLE;
        end
        mmbox_pkg::S_SCAN: begin
          if (32'(cnt) >= SLOT_COUNT) begin
            wcnt <= '0;
            state <= found ? mmbox_pkg::S_READ : mmbox_pkg::S_RESP;
          end else begin
            if (slot_busy[cur] && slot_dest[cur] == r_dest
                && (!found || slot_order[cur] < best_order)) begin
              found <= 1'b1;
              best <= cur;
              best_order <= slot_order[cur];
            end
            cnt <= cnt + 1'b1;
          end
        end
        mmbox_pkg::S_READ: begin
          if (!m_axis_tvalid) state <= mmbox_pkg::S_EMIT;
        end
        mmbox_pkg::S_EMIT: begin
          m_axis_tvalid <= 1'b1;
          m_axis_tdata <= {1'b0, keep_bytes(rd_word, slot_length[best], wsel),
                           slot_length[best], slot_dest[best], slot_sender[best],
                           mmbox_pkg::ST_OK};
          m_axis_tlast <= (32'(wcnt) == WORDS - 1);
          if (32'(wcnt) == WORDS - 1) begin
            slot_busy[best] <= 1'b0;
            state <= mmbox_pkg::S_IDLE;
          end else begin
            wcnt <= wcnt + 1'b1;
            state <= mmbox_pkg::S_READ;
          end
        end
        mmbox_pkg::S_RESP: begin
          m_axis_tvalid <= 1'b1;
          m_axis_tdata <= {103'd0, mmbox_pkg::ST_FAIL};
          m_axis_tlast <= 1'b1;
          state <= mmbox_pkg::S_IDLE;
        end
        default: state <= mmbox_pkg::S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> state == mmbox_pkg::S_IDLE)
    else $error("ready outside idle");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result overwritten under stall");
  a_order_rises: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && (next_order != $past(next_order)) |-> next_order == $past(next_order) + 64'd1)
    else $error("order counter jumped");
endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Testbench for the slot-based message mailbox: directed and random send and
// receive traffic, checked beat by beat against a behavioral mailbox model.
// Depends on mmbox_pkg and message_mailbox_slots.
`timescale 1ns / 1ps
module testbench;

  localparam int SLOTS = 16;
  localparam int WORDS = 4;
  localparam int MAXB  = 32;

  typedef struct packed {
    logic        status;
    logic [15:0] from_id;
    logic [15:0] to_id;
    logic [5:0]  msg_length;
    logic [63:0] out_word;
    logic        last;
  } beat_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic         m_axis_tlast;

  message_mailbox_slots dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // Model state of the mailbox.
  logic        box_busy [SLOTS];
  logic [15:0] box_from [SLOTS];
  logic [15:0] box_to   [SLOTS];
  logic [5:0]  box_len  [SLOTS];
  logic [63:0] box_ord  [SLOTS];
  logic [63:0] box_word [SLOTS][WORDS];
  logic [63:0] order_ctr;
  int          open_slot;
  logic        open_ok;

  beat_t expected_beats[$];
  int    errors = 0;
  int    send_idle = 0;
  int    recv_stall = 0;

  task automatic report(input string what);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  function automatic logic [63:0] trim_word(logic [63:0] d, logic [5:0] len, int w);
    int kept;
    kept = int'(len) - w * 8;
    if (kept <= 0) return 64'd0;
    if (kept >= 8) return d;
    return d & ((64'd1 << (8 * kept)) - 64'd1);
  endfunction

  function automatic beat_t fail_beat(logic st);
    beat_t b;
    b = '0;
    b.status = st;
    b.last = 1'b1;
    return b;
  endfunction

  task automatic predict_mailbox(logic kind, logic [15:0] snd, logic [15:0] dst,
                                 logic [5:0] cnt, logic [1:0] widx,
                                 logic [63:0] data, logic lastw);
    int i;
    int best;
    beat_t b;
    if (kind == mmbox_pkg::REQ_SEND) begin
      if (widx == 0) begin
        open_ok = 1'b0;
        if (snd != 0 && dst != 0 && cnt >= 1 && cnt <= MAXB) begin
          for (i = 0; i < SLOTS; i++) if (!box_busy[i]) break;
          if (i < SLOTS) begin
            open_slot = i;
            open_ok = 1'b1;
            box_from[i] = snd;
            box_to[i] = dst;
            box_len[i] = cnt;
            for (int w = 0; w < WORDS; w++) box_word[i][w] = '0;
          end
        end
      end
      if (open_ok) box_word[open_slot][widx] = trim_word(data, box_len[open_slot], widx);
      if (lastw) begin
        if (open_ok) begin
          box_busy[open_slot] = 1'b1;
          box_ord[open_slot] = order_ctr;
          order_ctr++;
          expected_beats.push_back(fail_beat(mmbox_pkg::ST_OK));
        end else begin
          expected_beats.push_back(fail_beat(mmbox_pkg::ST_FAIL));
        end
        open_ok = 1'b0;
      end
    end else begin
      best = -1;
      if (dst != 0)
        for (i = 0; i < SLOTS; i++)
          if (box_busy[i] && box_to[i] == dst && (best < 0 || box_ord[i] < box_ord[best]))
            best = i;
      if (best < 0) begin
        expected_beats.push_back(fail_beat(mmbox_pkg::ST_FAIL));
      end else begin
        for (int w = 0; w < WORDS; w++) begin
          b.status = mmbox_pkg::ST_OK;
          b.from_id = box_from[best];
          b.to_id = box_to[best];
          b.msg_length = box_len[best];
          b.out_word = trim_word(box_word[best][w], box_len[best], w);
          b.last = (w == WORDS - 1);
          expected_beats.push_back(b);
        end
        box_busy[best] = 1'b0;
      end
    end
  endtask

  // Drives one request beat, then predicts its results once accepted.
  // tvalid stays high on return so that a following beat can go out back to back.
  task automatic send_beat(logic kind, logic [15:0] snd, logic [15:0] dst,
                           logic [5:0] cnt, logic [1:0] widx, logic [63:0] data,
                           logic lastw);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tlast <= lastw;
    s_axis_tdata <= {data, widx, cnt, dst, snd};
    do @(posedge clk); while (!s_axis_tready);
    predict_mailbox(kind, snd, dst, cnt, widx, data, lastw);
    @(negedge clk);
  endtask

  task automatic send_message(logic [15:0] snd, logic [15:0] dst, logic [5:0] cnt, int nw);
    for (int w = 0; w < nw; w++)
      send_beat(mmbox_pkg::REQ_SEND, snd, dst, cnt, w[1:0], {$urandom, $urandom},
                w == nw - 1);
  endtask

  task automatic recv_message(logic [15:0] dst);
    send_beat(mmbox_pkg::REQ_RECV, 16'($urandom), dst, 6'($urandom), 2'($urandom),
              {$urandom, $urandom}, 1'($urandom));
  endtask

  task automatic wait_drained;
    s_axis_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  // Result checker.
  always @(posedge clk) begin
    beat_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[0], m_axis_tdata[16:1], m_axis_tdata[32:17],
             m_axis_tdata[38:33], m_axis_tdata[102:39], m_axis_tlast};
      if (expected_beats.size() == 0) begin
        report("unexpected result beat");
      end else begin
        want = expected_beats.pop_front();
        if (got.status !== want.status) report("status");
        if (got.from_id !== want.from_id) report("from_id");
        if (got.to_id !== want.to_id) report("to_id");
        if (got.msg_length !== want.msg_length) report("msg_length");
        if (got.out_word !== want.out_word) report("out_word");
        if (got.last !== want.last) report("last");
      end
    end
  end

  always @(negedge clk) begin
    m_axis_tready <= (recv_stall == 0) || ($urandom_range(99) >= recv_stall);
  end

  task automatic test_directed;
    send_message(16'hFFFF, 16'h0001, 6'd32, 4);
    send_message(16'h0001, 16'hFFFF, 6'd1, 1);
    send_message(16'h0000, 16'h0002, 6'd8, 1);
    send_message(16'h0002, 16'h0000, 6'd8, 1);
    send_message(16'h0003, 16'h0001, 6'd0, 1);
    send_message(16'h0003, 16'h0001, 6'd33, 2);
    send_message(16'h0003, 16'h0001, 6'd63, 1);
    send_message(16'h0004, 16'h0001, 6'd13, 2);
    // Word with no open send, then a restart that abandons a run.
    send_beat(mmbox_pkg::REQ_SEND, 16'h5, 16'h1, 6'd8, 2'd2, '1, 1'b1);
    send_beat(mmbox_pkg::REQ_SEND, 16'h5, 16'h1, 6'd8, 2'd0, '1, 1'b0);
    send_beat(mmbox_pkg::REQ_RECV, 16'h0, 16'h1, 6'd0, 2'd0, '0, 1'b0);
    send_message(16'h0006, 16'h0007, 6'd20, 3);
    recv_message(16'h0001);
    recv_message(16'h0001);
    recv_message(16'h0000);
    recv_message(16'h0009);
    recv_message(16'hFFFF);
    wait_drained();
  endtask

  task automatic test_full_box;
    for (int i = 0; i < SLOTS + 1; i++) send_message(16'h11, 16'h22, 6'd5, 1);
    for (int i = 0; i < SLOTS + 1; i++) recv_message(16'h22);
    wait_drained();
  endtask

  task automatic test_random(int n, int idle, int stall);
    int cnt, nw, r;
    send_idle = idle;
    recv_stall = stall;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(9);
      cnt = $urandom_range(1, 32);
      nw = $urandom_range(1, 4);
      if (r < 5) send_message(16'($urandom_range(1, 3)), 16'($urandom_range(1, 3)),
                              6'(cnt), nw);
      else if (r < 8) recv_message(16'($urandom_range(0, 3)));
      else send_beat(mmbox_pkg::REQ_SEND, 16'($urandom), 16'($urandom), 6'($urandom),
                     2'($urandom), {$urandom, $urandom}, 1'($urandom));
    end
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) box_busy[i] = 1'b0;
    order_ctr = 64'd1;
    open_slot = 0;
    open_ok = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_box();
    test_random(8, 0, 0);
    test_random(6, 84, 0);
    test_random(6, 0, 84);
    test_random(6, 6, 6);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
